// File: hdl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// shared constants for the pacing rate controller: register indexes, law
// modes, field widths and the fixed arithmetic constants
// ----------------------------------------------------------------------------
package prc_pkg;

    // field widths
    localparam int QUEUE_W    = 24;
    localparam int PERIOD_W   = 24;
    localparam int SPACING_W  = 24;
    localparam int RATE_W     = 32;
    localparam int COEF_W     = 16;
    localparam int DELTA_W    = 12;
    localparam int MS_W       = 10;
    localparam int PLAY_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Q4.12 / Q0.12 product shift
    localparam int Q_SHIFT = 12;

    localparam int unsigned USEC_PER_SEC = 1000000;
    localparam int unsigned MS_PER_SEC   = 1000;

    localparam logic [SPACING_W-1:0] SPACING_MAX = '1;
    localparam logic [RATE_W-1:0]    RATE_MAX    = '1;

    // control law codes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_AIMD = 2'd1;
    localparam logic [1:0] MODE_PROP = 2'd2;
    localparam logic [1:0] MODE_PLAY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAW_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ADD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_COEF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_COEF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MS      = 3'd5;

endpackage

// File: hdl/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div
// radix-2 restoring divider, one quotient bit per cycle, shared by the
// initial rate, playout rate and spacing computations
// ----------------------------------------------------------------------------
module prc_div #(
    parameter int DW = 28
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DW-1:0]             i_dividend,
    input  logic [prc_pkg::RATE_W-1:0] i_divisor,
    output logic [DW-1:0]             o_quotient,
    output logic                      o_done
);

    localparam int CW = $clog2(DW + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [prc_pkg::RATE_W-1:0]  r_rem;
    logic [prc_pkg::RATE_W-1:0]  r_dsr;
    logic [DW-1:0]               r_dvd;

    logic [prc_pkg::RATE_W:0]    rem_sh;
    logic                        q_bit;
    logic [prc_pkg::RATE_W:0]    rem_sub;

    assign rem_sh  = {r_rem, r_dvd[DW-1]};
    assign q_bit   = rem_sh >= {1'b0, r_dsr};
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_dvd  <= i_dividend;
            end else if (r_busy) begin
                // quotient bits shift in where dividend bits leave
                r_rem <= q_bit ? rem_sub[prc_pkg::RATE_W-1:0] : rem_sh[prc_pkg::RATE_W-1:0];
                r_dvd <= {r_dvd[DW-2:0], q_bit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quotient = r_dvd;
    assign o_done     = r_done;

endmodule

// File: hdl/pacing_rate_controller_top.sv
// ----------------------------------------------------------------------------
// pacing_rate_controller_top
// queue-feedback rate control: updates a sending rate from receiver feedback
// and returns the new rate and inter-packet spacing
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries one feedback item: queue
//   level, target level and playout period. output channel (o_out_valid /
//   i_out_stall) returns spacing in us, the 24.8 rate and a clamp flag.
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
// sequencing:
//   one item at a time; o_in_stall is high from acceptance until the result
//   is loaded into the output register, and the next item can then be
//   accepted. one shared divider makes one quotient bit per cycle over
//   20 + RATE_FRAC_BITS bits. mode 3 adds a playout-rate division unless the
//   playout period is zero, and the first item after reset adds one for the
//   initial rate; a clamp swaps the spacing division for an equal one.
// reset:
//   control and configuration registers return to their defaults and the rate
//   is reloaded from the initial spacing on the next item.
// stall:
//   a new item is accepted while a result waits; its result is held in the
//   sequencer until the output register is free.
// ----------------------------------------------------------------------------
module pacing_rate_controller_top #(
    parameter int RATE_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // feedback items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [prc_pkg::QUEUE_W-1:0]       i_queue_now,
    input  logic [prc_pkg::QUEUE_W-1:0]       i_queue_target,
    input  logic [prc_pkg::PERIOD_W-1:0]      i_playout_period_us,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [prc_pkg::SPACING_W-1:0]     o_spacing_us,
    output logic [prc_pkg::RATE_W-1:0]        o_rate_fixed,
    output logic                              o_rate_clamped
);

    localparam int DW   = prc_pkg::PLAY_W + RATE_FRAC_BITS;
    localparam int MAGW = (DW > prc_pkg::RATE_W) ? DW : prc_pkg::RATE_W;
    localparam int PW   = MAGW + prc_pkg::COEF_W;
    localparam int WW   = PW + RATE_FRAC_BITS;

    localparam logic [DW-1:0] SPC_DVD  = DW'(64'(prc_pkg::USEC_PER_SEC) << RATE_FRAC_BITS);
    localparam logic [DW-1:0] INIT_DVD = DW'(64'(prc_pkg::MS_PER_SEC) << RATE_FRAC_BITS);
    localparam logic [DW-1:0] PLAY_DVD = DW'(prc_pkg::USEC_PER_SEC);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_LAW,
        S_MUL_D,
        S_ACC_D,
        S_MUL_E,
        S_ACC_E,
        S_PLAY,
        S_DIFF,
        S_MUL_B,
        S_ACC_B,
        S_FIN,
        S_SPACE,
        S_CLAMP,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [1:0]                    r_mode;
    logic [prc_pkg::COEF_W-1:0]    r_step;
    logic [prc_pkg::DELTA_W-1:0]   r_delta;
    logic [prc_pkg::COEF_W-1:0]    r_eps;
    logic [prc_pkg::COEF_W-1:0]    r_beta;
    logic [prc_pkg::MS_W-1:0]      r_ims;

    // rate state
    logic [prc_pkg::RATE_W-1:0]    r_rate;
    logic                          r_started;

    // latched item
    logic [prc_pkg::QUEUE_W-1:0]   r_qn;
    logic [prc_pkg::QUEUE_W-1:0]   r_qt;
    logic [prc_pkg::PERIOD_W-1:0]  r_per;

    // datapath
    logic [WW:0]                   r_acc;
    logic [MAGW-1:0]               r_mul_a;
    logic [prc_pkg::COEF_W-1:0]    r_mul_b;
    logic [PW-1:0]                 r_prod;
    logic                          r_dneg;
    logic [prc_pkg::PLAY_W-1:0]    r_play;

    // divider request
    logic                          r_div_start;
    logic [DW-1:0]                 r_div_dvd;
    logic [prc_pkg::RATE_W-1:0]    r_div_dsr;
    logic [DW-1:0]                 div_q;
    logic                          div_done;

    // staged and output result
    logic [prc_pkg::SPACING_W-1:0] r_res_spacing;
    logic [prc_pkg::RATE_W-1:0]    r_res_rate;
    logic                          r_res_clamped;
    logic                          r_out_valid;
    logic [prc_pkg::SPACING_W-1:0] r_out_spacing;
    logic [prc_pkg::RATE_W-1:0]    r_out_rate;
    logic                          r_out_clamped;

    logic [prc_pkg::MS_W-1:0]      eff_ms;
    logic                          q_lt;
    logic                          q_gt;
    logic [prc_pkg::QUEUE_W-1:0]   err_mag;
    logic [WW:0]                   step_fx;
    logic [WW:0]                   rate_x;
    logic [WW:0]                   prod_x;
    logic [WW:0]                   t_eps;
    logic [WW:0]                   t_q12;
    logic [MAGW-1:0]               play_fx;
    logic [MAGW-1:0]               rate_m;
    logic                          d_neg;
    logic [MAGW-1:0]               d_mag;
    logic                          acc_pos;
    logic                          acc_big;
    logic [prc_pkg::RATE_W-1:0]    n_rate;
    logic [prc_pkg::RATE_W-1:0]    div_q32;
    logic [prc_pkg::RATE_W-1:0]    init_rate;
    logic [prc_pkg::SPACING_W-1:0] clamp_spacing;
    logic                          in_accept;

    prc_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dsr),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    // shared multiplier, one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= r_mul_a * r_mul_b;
    end

    always_comb begin
        eff_ms  = (r_ims == '0) ? prc_pkg::MS_W'(1) : r_ims;
        q_lt    = r_qn < r_qt;
        q_gt    = r_qn > r_qt;
        err_mag = q_gt ? (r_qn - r_qt) : (r_qt - r_qn);
        step_fx = (WW+1)'(r_step) << RATE_FRAC_BITS;
        rate_x  = (WW+1)'(r_rate);
        prod_x  = (WW+1)'(r_prod);
        // queue term carries the extra fixed-point unit before the q12 shift
        t_eps   = (prod_x << RATE_FRAC_BITS) >> prc_pkg::Q_SHIFT;
        t_q12   = prod_x >> prc_pkg::Q_SHIFT;
        play_fx = MAGW'(r_play) << RATE_FRAC_BITS;
        rate_m  = MAGW'(r_rate);
        d_neg   = play_fx > rate_m;
        d_mag   = d_neg ? (play_fx - rate_m) : (rate_m - play_fx);
        acc_pos = !r_acc[WW] && (r_acc != '0);
        acc_big = |r_acc[WW-1:prc_pkg::RATE_W];
        if (!acc_pos) begin
            n_rate = prc_pkg::RATE_W'(1);
        end else if (acc_big) begin
            n_rate = prc_pkg::RATE_MAX;
        end else begin
            n_rate = r_acc[prc_pkg::RATE_W-1:0];
        end
        div_q32       = prc_pkg::RATE_W'(div_q);
        init_rate     = (div_q32 == '0) ? prc_pkg::RATE_W'(1) : div_q32;
        clamp_spacing = prc_pkg::SPACING_W'(32'(eff_ms) * 32'(prc_pkg::MS_PER_SEC));
        in_accept     = i_in_valid && (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_rate      <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= prc_pkg::MODE_ADD;
            r_step      <= prc_pkg::COEF_W'(1);
            r_delta     <= prc_pkg::DELTA_W'(2048);
            r_eps       <= prc_pkg::COEF_W'(410);
            r_beta      <= prc_pkg::COEF_W'(4506);
            r_ims       <= prc_pkg::MS_W'(10);
        end else begin
            // start is a one-cycle pulse; no state raises it while it is high
            if (r_div_start) begin
                r_div_start <= 1'b0;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    prc_pkg::CFG_LAW_MODE:     r_mode  <= i_cfg_data[1:0];
                    prc_pkg::CFG_STEP_ADD:     r_step  <= i_cfg_data;
                    prc_pkg::CFG_DELTA_COEF:   r_delta <= i_cfg_data[prc_pkg::DELTA_W-1:0];
                    prc_pkg::CFG_EPSILON_COEF: r_eps   <= i_cfg_data;
                    prc_pkg::CFG_BETA_COEF:    r_beta  <= i_cfg_data;
                    prc_pkg::CFG_INIT_MS:      r_ims   <= i_cfg_data[prc_pkg::MS_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_qn  <= i_queue_now;
                        r_qt  <= i_queue_target;
                        r_per <= i_playout_period_us;
                        if (!r_started) begin
                            r_div_start <= 1'b1;
                            r_div_dvd   <= INIT_DVD;
                            r_div_dsr   <= prc_pkg::RATE_W'(eff_ms);
                            r_state     <= S_INIT;
                        end else begin
                            r_state <= S_LAW;
                        end
                    end
                end
                S_INIT: begin
                    if (div_done) begin
                        r_rate    <= init_rate;
                        r_started <= 1'b1;
                        r_state   <= S_LAW;
                    end
                end
                S_LAW: begin
                    unique case (r_mode)
                        prc_pkg::MODE_ADD: begin
                            if (q_lt) begin
                                r_acc <= rate_x + step_fx;
                            end else if (q_gt) begin
                                r_acc <= rate_x - step_fx;
                            end else begin
                                r_acc <= rate_x;
                            end
                            r_state <= S_FIN;
                        end
                        prc_pkg::MODE_AIMD: begin
                            if (q_lt) begin
                                r_acc   <= rate_x + step_fx;
                                r_state <= S_FIN;
                            end else if (q_gt) begin
                                r_mul_a <= MAGW'(r_rate);
                                r_mul_b <= prc_pkg::COEF_W'(r_delta);
                                r_state <= S_MUL_D;
                            end else begin
                                r_acc   <= rate_x;
                                r_state <= S_FIN;
                            end
                        end
                        prc_pkg::MODE_PROP, prc_pkg::MODE_PLAY: begin
                            r_acc   <= rate_x;
                            r_mul_a <= MAGW'(err_mag);
                            r_mul_b <= r_eps;
                            r_state <= S_MUL_E;
                        end
                        default: begin
                            r_acc   <= rate_x;
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_MUL_D: r_state <= S_ACC_D;
                S_ACC_D: begin
                    r_acc   <= t_q12;
                    r_state <= S_FIN;
                end
                S_MUL_E: r_state <= S_ACC_E;
                S_ACC_E: begin
                    r_acc <= q_gt ? (r_acc - t_eps) : (r_acc + t_eps);
                    if (r_mode != prc_pkg::MODE_PLAY) begin
                        r_state <= S_FIN;
                    end else if (r_per == '0) begin
                        r_play  <= '0;
                        r_state <= S_DIFF;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_dvd   <= PLAY_DVD;
                        r_div_dsr   <= prc_pkg::RATE_W'(r_per);
                        r_state     <= S_PLAY;
                    end
                end
                S_PLAY: begin
                    if (div_done) begin
                        r_play  <= prc_pkg::PLAY_W'(div_q);
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_mul_a <= d_mag;
                    r_mul_b <= r_beta;
                    r_dneg  <= d_neg;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: r_state <= S_ACC_B;
                S_ACC_B: begin
                    // subtracting beta times a negative gap raises the rate
                    r_acc   <= r_dneg ? (r_acc + t_q12) : (r_acc - t_q12);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!acc_pos && (r_mode == prc_pkg::MODE_PROP ||
                                     r_mode == prc_pkg::MODE_PLAY)) begin
                        r_res_spacing <= clamp_spacing;
                        r_res_rate    <= '0;
                        r_res_clamped <= 1'b1;
                        r_div_start   <= 1'b1;
                        r_div_dvd     <= INIT_DVD;
                        r_div_dsr     <= prc_pkg::RATE_W'(eff_ms);
                        r_state       <= S_CLAMP;
                    end else begin
                        r_rate        <= n_rate;
                        r_res_rate    <= n_rate;
                        r_res_clamped <= 1'b0;
                        r_div_start   <= 1'b1;
                        r_div_dvd     <= SPC_DVD;
                        r_div_dsr     <= n_rate;
                        r_state       <= S_SPACE;
                    end
                end
                S_SPACE: begin
                    if (div_done) begin
                        r_res_spacing <= (64'(div_q) > 64'(prc_pkg::SPACING_MAX)) ?
                                         prc_pkg::SPACING_MAX : prc_pkg::SPACING_W'(div_q);
                        r_state       <= S_OUT;
                    end
                end
                S_CLAMP: begin
                    if (div_done) begin
                        r_rate  <= init_rate;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_out_spacing <= r_res_spacing;
                        r_out_rate    <= r_res_rate;
                        r_out_clamped <= r_res_clamped;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_spacing_us   = r_out_spacing;
    assign o_rate_fixed   = r_out_rate;
    assign o_rate_clamped = r_out_clamped;

endmodule

// File: dv/tb_pacing_rate_controller_top.sv
// ----------------------------------------------------------------------------
// tb_pacing_rate_controller_top
// self-checking bench for the queue-feedback pacing rate controller: feedback
// items go in over a valid/stall channel while an in-bench predictor tracks the
// sending rate under every control law; each returned spacing, rate and clamp
// flag is compared with the oldest prediction
// ----------------------------------------------------------------------------
module tb_pacing_rate_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC           = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RAND_PHASES    = 11;
    localparam int PHASE_ITEMS    = 48;

    typedef logic [prc_pkg::QUEUE_W-1:0]    t_queue;
    typedef logic [prc_pkg::PERIOD_W-1:0]   t_period;
    typedef logic [prc_pkg::SPACING_W-1:0]  t_spacing;
    typedef logic [prc_pkg::RATE_W-1:0]     t_rate;
    typedef logic [prc_pkg::CFG_DATA_W-1:0] t_cfg_word;
    typedef logic [prc_pkg::CFG_IDX_W-1:0]  t_cfg_idx;

    typedef struct packed {
        t_spacing spacing;
        t_rate    rate;
        logic     clamped;
    } t_rate_result;

    localparam t_queue   QMAX = '1;
    localparam t_period  PMAX = '1;
    localparam t_cfg_idx REG_ORDER [6] = '{prc_pkg::CFG_LAW_MODE, prc_pkg::CFG_STEP_ADD,
                                           prc_pkg::CFG_DELTA_COEF,
                                           prc_pkg::CFG_EPSILON_COEF,
                                           prc_pkg::CFG_BETA_COEF, prc_pkg::CFG_INIT_MS};

    logic      i_clk          = 1'b0;
    logic      i_rst_n        = 1'b0;
    logic      i_cfg_we       = 1'b0;
    t_cfg_idx  i_cfg_idx      = '0;
    t_cfg_word i_cfg_data     = '0;
    logic      i_in_valid     = 1'b0;
    t_queue    i_queue_now    = '0;
    t_queue    i_queue_target = '0;
    t_period   i_playout_period_us = '0;
    logic      i_out_stall    = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_spacing  o_spacing_us;
    t_rate     o_rate_fixed;
    logic      o_rate_clamped;

    // shadow registers and rate state of the predictor
    logic [1:0]                  cur_mode  = prc_pkg::MODE_ADD;
    logic [15:0]                 cur_step  = 16'd1;
    logic [prc_pkg::DELTA_W-1:0] cur_delta = 12'd2048;
    logic [prc_pkg::COEF_W-1:0]  cur_eps   = 16'd410;
    logic [prc_pkg::COEF_W-1:0]  cur_beta  = 16'd4506;
    logic [prc_pkg::MS_W-1:0]    cur_ms    = 10'd10;
    t_rate                       pred_rate   = '0;
    logic                        pred_loaded = 1'b0;

    t_rate_result rate_expect_q[$];
    bit rx_hold_req     = 1'b0;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int clamps_seen     = 0;
    int settings_loaded = 0;

    pacing_rate_controller_top #(.RATE_FRAC_BITS(FRAC)) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_queue_now         (i_queue_now),
        .i_queue_target      (i_queue_target),
        .i_playout_period_us (i_playout_period_us),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_spacing_us        (o_spacing_us),
        .o_rate_fixed        (o_rate_fixed),
        .o_rate_clamped      (o_rate_clamped)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_ms();
        return (cur_ms == 0) ? 1 : int'(cur_ms);
    endfunction

    function automatic t_rate start_rate();
        longint unsigned r;
        r = (64'(prc_pkg::MS_PER_SEC) << FRAC) / eff_ms();
        return (r == 0) ? t_rate'(1) : t_rate'(r);
    endfunction

    function automatic t_spacing spacing_for(t_rate r);
        longint unsigned s;
        s = (64'(prc_pkg::USEC_PER_SEC) << FRAC) / r;
        return (s > prc_pkg::SPACING_MAX) ? prc_pkg::SPACING_MAX : t_spacing'(s);
    endfunction

    // Q4.12 gain on a signed value, truncated toward zero
    function automatic longint q12_scale(logic [prc_pkg::COEF_W-1:0] coef, longint v);
        longint unsigned mag;
        longint unsigned p;
        mag = (v < 0) ? longint'(-v) : v;
        p = (mag * 64'(coef)) >> prc_pkg::Q_SHIFT;
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic t_rate sat_rate(longint unsigned r);
        if (r > 64'(prc_pkg::RATE_MAX))
            return prc_pkg::RATE_MAX;
        return (r == 0) ? t_rate'(1) : t_rate'(r);
    endfunction

    function automatic t_rate_result advance_rate(t_queue qn, t_queue qt, t_period per);
        t_rate_result    res;
        longint unsigned rate;
        longint unsigned step;
        longint          tgt;
        longint          now;
        longint          cur;
        longint          nr;
        longint          play;
        step = 64'(cur_step) << FRAC;
        if (!pred_loaded) begin
            pred_rate   = start_rate();
            pred_loaded = 1'b1;
        end
        rate = pred_rate;
        res.clamped = 1'b0;
        if (cur_mode == prc_pkg::MODE_ADD || cur_mode == prc_pkg::MODE_AIMD) begin
            if (qn < qt) begin
                rate = rate + step;
            end else if (qn > qt) begin
                if (cur_mode == prc_pkg::MODE_ADD)
                    rate = (rate > step) ? rate - step : 0;
                else
                    rate = (rate * 64'(cur_delta)) >> prc_pkg::Q_SHIFT;
            end
            pred_rate = sat_rate(rate);
        end else begin
            tgt = qt;
            now = qn;
            cur = rate;
            nr  = cur + q12_scale(cur_eps, (tgt - now) * (64'sd1 << FRAC));
            if (cur_mode == prc_pkg::MODE_PLAY) begin
                play = (per == 0) ? 0 : prc_pkg::USEC_PER_SEC / per;
                nr   = nr - q12_scale(cur_beta, cur - (play << FRAC));
            end
            if (nr <= 0) begin
                // clamp: report zero, fall back to the starting spacing
                pred_rate   = start_rate();
                res.spacing = t_spacing'(eff_ms() * prc_pkg::MS_PER_SEC);
                res.rate    = '0;
                res.clamped = 1'b1;
                return res;
            end
            pred_rate = sat_rate(longint'(nr));
        end
        res.spacing = spacing_for(pred_rate);
        res.rate    = pred_rate;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_rate_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (o_rate_clamped === 1'b1)
                clamps_seen++;
            if (rate_expect_q.size() == 0) begin
                $error("result with nothing expected: spacing_us %0d rate_fixed %0d",
                       o_spacing_us, o_rate_fixed);
                mismatch_count++;
            end else begin
                want = rate_expect_q.pop_front();
                if (o_spacing_us !== want.spacing) begin
                    $error("spacing_us expected %0d actual %0d", want.spacing, o_spacing_us);
                    mismatch_count++;
                end
                if (o_rate_fixed !== want.rate) begin
                    $error("rate_fixed expected %0d actual %0d", want.rate, o_rate_fixed);
                    mismatch_count++;
                end
                if (o_rate_clamped !== want.clamped) begin
                    $error("rate_clamped expected %0d actual %0d", want.clamped,
                           o_rate_clamped);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : rx_stall_pattern
        int pct;
        int span;
        pct  = 0;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                for (int n = 0; n < RX_HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    pct = 0;
                        2:       pct = 25;
                        3:       pct = 50;
                        default: pct = 85;
                    endcase
                    span = $urandom_range(16, 96);
                end
                span--;
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic load_settings(input t_cfg_word mode_w, input t_cfg_word step_w,
                                 input t_cfg_word delta_w, input t_cfg_word eps_w,
                                 input t_cfg_word beta_w, input t_cfg_word ms_w);
        t_cfg_word words [6];
        words = '{mode_w, step_w, delta_w, eps_w, beta_w, ms_w};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_ORDER[k];
            i_cfg_data <= words[k];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cur_mode  = mode_w[1:0];
        cur_step  = step_w;
        cur_delta = delta_w[prc_pkg::DELTA_W-1:0];
        cur_eps   = eps_w;
        cur_beta  = beta_w;
        cur_ms    = ms_w[prc_pkg::MS_W-1:0];
        settings_loaded++;
    endtask

    task automatic send_feedback(input t_queue qn, input t_queue qt, input t_period per);
        i_in_valid          <= 1'b1;
        i_queue_now         <= qn;
        i_queue_target      <= qt;
        i_playout_period_us <= per;
        do @(posedge i_clk); while (o_in_stall);
        rate_expect_q.push_back(advance_rate(qn, qt, per));
        items_sent++;
    endtask

    // sender pause: nothing more goes in until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (rate_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_cfg_word pick_word(t_cfg_word lo, t_cfg_word hi, int unsigned typ);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            2:       return t_cfg_word'($urandom());
            default: return t_cfg_word'($urandom_range(0, typ));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_feedback(24'd5, 24'd10, 24'd1000);
        send_feedback(QMAX, 24'd0, 24'd1000);
        send_feedback(24'd0, 24'd0, 24'd1000);
        drain_results();
    endtask

    task automatic test_additive_law();
        load_settings(prc_pkg::MODE_ADD, 16'hFFFF, 16'd2048, 16'd410, 16'd4506, 16'd10);
        send_feedback(24'd100, 24'd0, 24'd500);   // falls to the one-unit floor
        send_feedback(24'd0, QMAX, 24'd500);
        send_feedback(24'd7, 24'd7, 24'd500);
        drain_results();
        load_settings(prc_pkg::MODE_ADD, 16'd0, 16'd2048, 16'd410, 16'd4506, 16'd10);
        send_feedback(24'd0, 24'd1, 24'd500);
        drain_results();
    endtask

    task automatic test_aimd_law();
        load_settings(prc_pkg::MODE_AIMD, 16'd1, 16'd0, 16'd410, 16'd4506, 16'd10);
        send_feedback(24'd9, 24'd3, 24'd500);
        send_feedback(24'd3, 24'd9, 24'd500);
        drain_results();
        load_settings(prc_pkg::MODE_AIMD, 16'd1, 16'd4095, 16'd410, 16'd4506, 16'd10);
        send_feedback(QMAX, 24'd0, 24'd500);
        send_feedback(24'd42, 24'd42, 24'd500);
        drain_results();
    endtask

    task automatic test_proportional_law();
        load_settings(prc_pkg::MODE_PROP, 16'd1, 16'd2048, 16'hFFFF, 16'd4506, 16'd1);
        send_feedback(24'd0, QMAX, 24'd500);      // saturates the rate
        send_feedback(24'd1234, 24'd1234, 24'd500);
        send_feedback(QMAX, 24'd0, 24'd500);      // clamp
        drain_results();
        load_settings(prc_pkg::MODE_PROP, 16'd1, 16'd2048, 16'd0, 16'd4506, 16'd1);
        send_feedback(QMAX, 24'd0, 24'd500);
        drain_results();
    endtask

    task automatic test_playout_law();
        load_settings(prc_pkg::MODE_PLAY, 16'd1, 16'd2048, 16'd410, 16'hFFFF, 16'd999);
        send_feedback(24'd10, 24'd20, 24'd0);     // playout rate taken as zero
        send_feedback(24'd10, 24'd20, 24'd1);
        send_feedback(24'd20, 24'd10, PMAX);
        drain_results();
        load_settings(prc_pkg::MODE_PLAY, 16'd1, 16'd2048, 16'd410, 16'd0, 16'd999);
        send_feedback(24'd10, 24'd300, 24'd2000);
        drain_results();
        load_settings(prc_pkg::MODE_PLAY, 16'd1, 16'd2048, 16'd410, 16'd4096, 16'd999);
        send_feedback(24'd50, 24'd60, 24'd1000);
        drain_results();
    endtask

    task automatic test_zero_initial_spacing();
        // zero spacing register behaves as one millisecond
        load_settings(prc_pkg::MODE_PROP, 16'd1, 16'd2048, 16'hFFFF, 16'd4506, 16'd0);
        send_feedback(QMAX, 24'd0, 24'd500);
        send_feedback(24'd8, 24'd8, 24'd500);
        drain_results();
    endtask

    task automatic test_max_initial_spacing();
        load_settings(prc_pkg::MODE_PROP, 16'd1, 16'd2048, 16'hFFFF, 16'd4506, 16'h03FF);
        send_feedback(QMAX, 24'd0, 24'd500);
        send_feedback(24'd8, 24'd8, 24'd500);
        drain_results();
    endtask

    // receiver holds off while items keep coming, so the input side backs up
    task automatic test_backpressure();
        load_settings(prc_pkg::MODE_AIMD, 16'd3, 16'd3000, 16'd410, 16'd4506, 16'd20);
        rx_hold_req = 1'b1;
        for (int n = 0; n < 12; n++)
            send_feedback(t_queue'($urandom_range(0, 40)), t_queue'($urandom_range(0, 40)),
                          t_period'($urandom_range(1, 5000)));
        drain_results();
    endtask

    task automatic test_random_traffic();
        t_cfg_word mode_w;
        t_queue    qn;
        t_queue    qt;
        t_period   per;
        int        burst_left;
        bit        gaps_on;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            mode_w = t_cfg_word'(phase % 4);
            if ($urandom_range(0, 3) == 0)
                mode_w = mode_w | (t_cfg_word'($urandom()) & 16'hFFFC);
            load_settings(mode_w,
                          pick_word(16'd0, 16'hFFFF, 64),
                          pick_word(16'd0, 16'd4095, 4095),
                          pick_word(16'd0, 16'hFFFF, 2047),
                          pick_word(16'd0, 16'hFFFF, 8191),
                          pick_word(16'd0, 16'h03FF, 999));
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                qt = t_queue'($urandom());
                case ($urandom_range(0, 7))
                    0:       qn = qt;
                    1, 2, 3: qn = qt + t_queue'($urandom_range(0, 511)) - 24'd256;
                    4, 5:    qn = qt + t_queue'($urandom_range(0, 131071)) - 24'd65536;
                    default: qn = t_queue'($urandom());
                endcase
                case ($urandom_range(0, 9))
                    0:       per = '0;
                    1:       per = 24'd1;
                    2:       per = PMAX;
                    3, 4:    per = t_period'($urandom());
                    default: per = t_period'($urandom_range(50, 200000));
                endcase
                send_feedback(qn, qt, per);
                burst_left--;
                if (burst_left == 0) begin
                    if (gaps_on) begin
                        i_in_valid <= 1'b0;
                        repeat ($urandom_range(1, 20)) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_additive_law();
        test_aimd_law();
        test_proportional_law();
        test_playout_law();
        test_zero_initial_spacing();
        test_max_initial_spacing();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run: %0d feedback items, %0d results checked, %0d register settings",
                 items_sent, results_checked, settings_loaded);
        $display("all four laws, floor/clamp/saturation cases, %0d clamps seen, %0d mismatches",
                 clamps_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", rate_expect_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
hdl/prc_pkg.sv
hdl/prc_div.sv
hdl/pacing_rate_controller_top.sv
dv/tb_pacing_rate_controller_top.sv
